// ----- design/stff_pkg.sv -----
// Package for the keyed slot table: codes, widths and default sizing.
package stff_pkg;

   localparam int SLOT_COUNT_DEF = 16;

   localparam int CMD_W = 2;
   localparam int KEY_W = 64;
   localparam int TAG_W = 16;
   localparam int STAT_W = 2;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_PARK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [TAG_W-1:0] tag_type;

endpackage

// ----- design/slot_table_first_free_keyed_core.sv -----
// Keyed slot table: first-free park, remove and lookup by key, one scan unit.
// Each scan reads the slots in order up to the hit, then compares and updates; a miss or
// a full table reads every slot and drains the last compare before the update. Command
// three skips the scan and answers OK with no table change; a stalled result word holds
// the update. One word in flight; ready returns with the result word, and no new word is
// accepted before then.
module slot_table_first_free_keyed_core
   import stff_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [KEY_W-1:0]     req_plate_key,
   input  logic [TAG_W-1:0]     req_vehicle_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [INDEX_W-1:0]   rsp_slot_index,
   output logic [TAG_W-1:0]     rsp_tag_out,
   output logic [COUNT_W-1:0]   rsp_occupied_count,
   output logic                 rsp_is_full
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   key_type               key_ff, key_in;
   tag_type               tag_ff, tag_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  p_valid_ff, p_valid_in;
   logic                  p_used_ff, p_used_in;
   logic [IDX_W-1:0]      p_idx_ff, p_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   tag_type               hit_tag_ff, hit_tag_in;
   logic [SLOT_COUNT-1:0] slot_used_ff, slot_used_in;
   logic [CNT_W-1:0]      used_total_ff, used_total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]    rsp_slot_index_ff, rsp_slot_index_in;
   tag_type               rsp_tag_out_ff, rsp_tag_out_in;
   logic [COUNT_W-1:0]    rsp_occupied_count_ff, rsp_occupied_count_in;
   logic                  rsp_is_full_ff, rsp_is_full_in;

   key_type               key_mem [SLOT_COUNT];
   tag_type               tag_mem [SLOT_COUNT];
   key_type               rd_key_ff;
   tag_type               rd_tag_ff;

   logic                  issue_done;
   logic                  issue_en;
   logic [IDX_W-1:0]      issue_idx;
   logic                  is_park;
   logic                  hit;
   logic                  fire;
   logic                  wr_en;

   assign issue_idx  = issue_ff[IDX_W-1:0];
   assign issue_done = (issue_ff == CNT_W'(SLOT_COUNT));
   assign issue_en   = (state_ff == S_SCAN) && !issue_done;
   assign is_park    = (cmd_ff == CMD_PARK);
   assign hit        = p_valid_ff && (is_park ? !p_used_ff : (p_used_ff && rd_key_ff == key_ff));
   assign fire       = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign wr_en      = fire && is_park && found_ff;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in              = state_ff;
      cmd_in                = cmd_ff;
      key_in                = key_ff;
      tag_in                = tag_ff;
      issue_in              = issue_ff;
      p_valid_in            = 1'b0;
      p_used_in             = p_used_ff;
      p_idx_in              = p_idx_ff;
      found_in              = found_ff;
      hit_idx_in            = hit_idx_ff;
      hit_tag_in            = hit_tag_ff;
      slot_used_in          = slot_used_ff;
      used_total_in         = used_total_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      rsp_status_in         = rsp_status_ff;
      rsp_slot_index_in     = rsp_slot_index_ff;
      rsp_tag_out_in        = rsp_tag_out_ff;
      rsp_occupied_count_in = rsp_occupied_count_ff;
      rsp_is_full_in        = rsp_is_full_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               key_in   = req_plate_key;
               tag_in   = req_vehicle_tag;
               issue_in = '0;
               found_in = 1'b0;
               if (req_command == CMD_PARK || req_command == CMD_REMOVE ||
                   req_command == CMD_LOOKUP) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (issue_en) begin
               p_valid_in = 1'b1;
               p_used_in  = slot_used_ff[issue_idx];
               p_idx_in   = issue_idx;
               issue_in   = issue_ff + 1'b1;
            end
            if (hit) begin
               found_in   = 1'b1;
               hit_idx_in = p_idx_ff;
               hit_tag_in = rd_tag_ff;
               p_valid_in = 1'b0;
               state_in   = S_FINISH;
            end else if (issue_done && !p_valid_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (fire) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = STAT_OK;
               rsp_slot_index_in = '0;
               rsp_tag_out_in    = '0;
               if (is_park) begin
                  if (found_ff) begin
                     slot_used_in[hit_idx_ff] = 1'b1;
                     used_total_in            = used_total_ff + 1'b1;
                     rsp_slot_index_in        = INDEX_W'(hit_idx_ff);
                  end else begin
                     rsp_status_in = STAT_FULL;
                  end
               end else if (cmd_ff == CMD_REMOVE || cmd_ff == CMD_LOOKUP) begin
                  if (found_ff) begin
                     rsp_slot_index_in = INDEX_W'(hit_idx_ff);
                     rsp_tag_out_in    = hit_tag_ff;
                     if (cmd_ff == CMD_REMOVE) begin
                        slot_used_in[hit_idx_ff] = 1'b0;
                        used_total_in            = used_total_ff - 1'b1;
                     end
                  end else begin
                     rsp_status_in = STAT_MISSING;
                  end
               end
               rsp_occupied_count_in = COUNT_W'(used_total_in);
               rsp_is_full_in        = (used_total_in >= CNT_W'(SLOT_COUNT));
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         p_valid_ff    <= 1'b0;
         slot_used_ff  <= '0;
         used_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         p_valid_ff    <= p_valid_in;
         slot_used_ff  <= slot_used_in;
         used_total_ff <= used_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff                <= cmd_in;
      key_ff                <= key_in;
      tag_ff                <= tag_in;
      issue_ff              <= issue_in;
      p_used_ff             <= p_used_in;
      p_idx_ff              <= p_idx_in;
      found_ff              <= found_in;
      hit_idx_ff            <= hit_idx_in;
      hit_tag_ff            <= hit_tag_in;
      rsp_status_ff         <= rsp_status_in;
      rsp_slot_index_ff     <= rsp_slot_index_in;
      rsp_tag_out_ff        <= rsp_tag_out_in;
      rsp_occupied_count_ff <= rsp_occupied_count_in;
      rsp_is_full_ff        <= rsp_is_full_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[hit_idx_ff] <= key_ff;
         tag_mem[hit_idx_ff] <= tag_ff;
      end
      if (issue_en) begin
         rd_key_ff <= key_mem[issue_idx];
         rd_tag_ff <= tag_mem[issue_idx];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_index     = rsp_slot_index_ff;
   assign rsp_tag_out        = rsp_tag_out_ff;
   assign rsp_occupied_count = rsp_occupied_count_ff;
   assign rsp_is_full        = rsp_is_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_total_ff <= CNT_W'(SLOT_COUNT))
      else $error("occupied count exceeds table size");

   a_count_matches_marks: assert property (@(posedge clock) disable iff (reset)
      used_total_ff == CNT_W'($countones(slot_used_ff)))
      else $error("occupied count disagrees with occupied marks");

   a_word_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("result word raised outside the update cycle");

   a_full_status_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STAT_FULL |-> rsp_is_full_ff)
      else $error("full status without full flag");

   a_marks_hold_while_scanning: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |=> $stable(slot_used_ff))
      else $error("occupied marks changed during a scan");

endmodule

// ----- tb/slot_table_first_free_keyed_core_tb.sv -----
// Testbench for the keyed slot table: directed table, random park/remove/lookup traffic.
`timescale 1ns / 1ps

module slot_table_first_free_keyed_core_tb;
   import stff_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1000;
   localparam int SEGMENT = 100;
   localparam int POOL_SIZE = 10;
   localparam key_type DUP_KEY = 64'h5555_5555_5555_5555;
   localparam key_type PLATE_BASE = 64'h5356_4A31_3230_3000;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [INDEX_W-1:0] slot_index;
      tag_type            tag_out;
      logic [COUNT_W-1:0] occupied_count;
      logic               is_full;
   } slot_result_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      key_type          key;
      tag_type          tag;
      bit               fixed;
      slot_result_type  want;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command = CMD_PARK;
   key_type             req_plate_key = '0;
   tag_type             req_vehicle_tag = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [INDEX_W-1:0]  rsp_slot_index;
   tag_type             rsp_tag_out;
   logic [COUNT_W-1:0]  rsp_occupied_count;
   logic                rsp_is_full;

   bit                  occ_mark [SLOT_COUNT_DEF];
   key_type             occ_key [SLOT_COUNT_DEF];
   tag_type             occ_tag [SLOT_COUNT_DEF];
   int                  occ_total = 0;

   slot_result_type     awaited_slot_results [$];
   directed_row_type    directed_rows [$];

   int                  error_count = 0;
   int                  words_sent = 0;
   int                  results_checked = 0;
   int                  full_rejects = 0;
   int                  key_misses = 0;
   int                  full_seen = 0;
   int                  burst_left = 0;

   logic [15:0]         stall_bits = 16'hFFFF;
   logic [6:0]          stall_age = '0;

   always #6 clock = ~clock;

   slot_table_first_free_keyed_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_plate_key      (req_plate_key),
      .req_vehicle_tag    (req_vehicle_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_tag_out        (rsp_tag_out),
      .rsp_occupied_count (rsp_occupied_count),
      .rsp_is_full        (rsp_is_full)
   );

   function automatic slot_result_type make_result(logic [STAT_W-1:0] status, int slot, int tag,
                                                   int count, bit full);
      slot_result_type r;
      r.status = status;
      r.slot_index = slot[INDEX_W-1:0];
      r.tag_out = tag[TAG_W-1:0];
      r.occupied_count = count[COUNT_W-1:0];
      r.is_full = full;
      return r;
   endfunction

   function automatic void add_directed(logic [CMD_W-1:0] cmd, key_type key, tag_type tag,
                                        bit fixed, slot_result_type want);
      directed_row_type row;
      row.cmd = cmd;
      row.key = key;
      row.tag = tag;
      row.fixed = fixed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   // Advance the table state by one word and return the reply it must produce.
   function automatic slot_result_type predict_slot_result(logic [CMD_W-1:0] cmd, key_type key,
                                                           tag_type tag);
      slot_result_type r;
      int i;
      int hit;
      r = make_result(STAT_OK, 0, 0, 0, 1'b0);
      hit = -1;
      case (cmd)
         CMD_PARK: begin
            for (i = 0; i < SLOT_COUNT_DEF; i++)
               if (hit < 0 && !occ_mark[i]) hit = i;
            if (hit < 0) begin
               r.status = STAT_FULL;
            end else begin
               occ_mark[hit] = 1'b1;
               occ_key[hit] = key;
               occ_tag[hit] = tag;
               occ_total++;
               r.slot_index = hit[INDEX_W-1:0];
            end
         end
         CMD_REMOVE, CMD_LOOKUP: begin
            for (i = 0; i < SLOT_COUNT_DEF; i++)
               if (hit < 0 && occ_mark[i] && occ_key[i] == key) hit = i;
            if (hit < 0) begin
               r.status = STAT_MISSING;
            end else begin
               r.slot_index = hit[INDEX_W-1:0];
               r.tag_out = occ_tag[hit];
               if (cmd == CMD_REMOVE) begin
                  occ_mark[hit] = 1'b0;
                  occ_total--;
               end
            end
         end
         default: ;
      endcase
      r.occupied_count = occ_total[COUNT_W-1:0];
      r.is_full = (occ_total >= SLOT_COUNT_DEF);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic drive_word(input logic [CMD_W-1:0] cmd, input key_type key, input tag_type tag,
                             input bit fixed, input slot_result_type want);
      slot_result_type predicted;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(99) < 40) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(20, 1);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_plate_key <= key;
      req_vehicle_tag <= tag;
      do @(posedge clock); while (!req_ready);
      predicted = predict_slot_result(cmd, key, tag);
      awaited_slot_results.push_back(fixed ? want : predicted);
      words_sent++;
   endtask

   always @(posedge clock) begin : rsp_side
      slot_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_bits <= 16'hFFFF;
         stall_age <= '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_slot_results.size() == 0) begin
               report_mismatch("word with nothing pending", 64'(rsp_status), 64'(0));
            end else begin
               want = awaited_slot_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_slot_index !== want.slot_index)
                  report_mismatch("slot_index", 64'(rsp_slot_index), 64'(want.slot_index));
               if (rsp_tag_out !== want.tag_out)
                  report_mismatch("tag_out", 64'(rsp_tag_out), 64'(want.tag_out));
               if (rsp_occupied_count !== want.occupied_count)
                  report_mismatch("occupied_count", 64'(rsp_occupied_count),
                                  64'(want.occupied_count));
               if (rsp_is_full !== want.is_full)
                  report_mismatch("is_full", 64'(rsp_is_full), 64'(want.is_full));
               results_checked++;
               if (want.status == STAT_FULL) full_rejects++;
               if (want.status == STAT_MISSING) key_misses++;
               if (want.is_full) full_seen++;
            end
         end
         rsp_ready <= stall_bits[0];
         stall_age <= stall_age + 7'd1;
         if (stall_age == 7'd127) begin
            case ($urandom_range(3))
               0: stall_bits <= 16'hFFFF;
               1: stall_bits <= 16'($urandom);
               2: stall_bits <= 16'h00FF;
               default: stall_bits <= 16'hAAAA;
            endcase
         end else begin
            stall_bits <= {stall_bits[0], stall_bits[15:1]};
         end
      end
   end

   initial begin : stimulus
      key_type key_pool [POOL_SIZE];
      key_type key;
      logic [CMD_W-1:0] cmd;
      int i;
      int roll;
      int park_pct;

      for (i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

      add_directed(CMD_LOOKUP, '0, '0, 1'b1, make_result(STAT_MISSING, 0, 0, 0, 1'b0));
      add_directed(CMD_REMOVE, '1, '0, 1'b1, make_result(STAT_MISSING, 0, 0, 0, 1'b0));
      add_directed(CMD_UNUSED, '1, '1, 1'b1, make_result(STAT_OK, 0, 0, 0, 1'b0));
      add_directed(CMD_PARK, '0, '0, 1'b1, make_result(STAT_OK, 0, 0, 1, 1'b0));
      add_directed(CMD_PARK, '1, '1, 1'b1, make_result(STAT_OK, 1, 0, 2, 1'b0));
      add_directed(CMD_LOOKUP, '1, 16'h1234, 1'b1, make_result(STAT_OK, 1, 'hFFFF, 2, 1'b0));
      add_directed(CMD_REMOVE, '0, '1, 1'b1, make_result(STAT_OK, 0, 0, 1, 1'b0));
      add_directed(CMD_PARK, DUP_KEY, 16'hAAAA, 1'b1, make_result(STAT_OK, 0, 0, 2, 1'b0));
      for (i = 2; i < SLOT_COUNT_DEF; i++)
         add_directed(CMD_PARK, (i % 3 == 0) ? DUP_KEY : PLATE_BASE + i, TAG_W'(i * 257),
                      1'b0, '0);
      add_directed(CMD_PARK, PLATE_BASE, 16'h0F0F, 1'b1,
                   make_result(STAT_FULL, 0, 0, SLOT_COUNT_DEF, 1'b1));
      add_directed(CMD_LOOKUP, DUP_KEY, '0, 1'b0, '0);
      add_directed(CMD_REMOVE, DUP_KEY, '0, 1'b0, '0);
      add_directed(CMD_REMOVE, DUP_KEY, '0, 1'b0, '0);
      add_directed(CMD_UNUSED, DUP_KEY, 16'h5A5A, 1'b0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_word(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].tag,
                    directed_rows[i].fixed, directed_rows[i].want);

      // Alternate fill and drain segments so the table swings between empty and full.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % SEGMENT == 0) key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
         park_pct = ((i / SEGMENT) % 2 == 0) ? 70 : 25;
         roll = $urandom_range(99);
         if (roll < park_pct) begin
            cmd = CMD_PARK;
         end else begin
            roll = $urandom_range(99);
            cmd = (roll < 55) ? CMD_REMOVE : (roll < 95) ? CMD_LOOKUP : CMD_UNUSED;
         end
         key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                         : {$urandom, $urandom};
         drive_word(cmd, key, TAG_W'($urandom), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (awaited_slot_results.size() != 0) @(posedge clock);
      repeat (SLOT_COUNT_DEF + 8) @(posedge clock);

      $display("sent %0d words, checked %0d replies", words_sent, results_checked);
      $display("full rejects %0d, key misses %0d, replies with table full %0d",
               full_rejects, key_misses, full_seen);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
